### sv/fta_pkg.sv
package fta_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TICKS_PER_MS = 2'd0;
  localparam logic [1:0] REG_TIME_SCALE   = 2'd1;
  localparam logic [1:0] REG_CLIP_MS      = 2'd2;
  localparam logic [1:0] REG_STEP_LEN     = 2'd3;

  localparam int CFG_DATA_W   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int HIST_DEPTH   = 4;
  localparam int DIV_W        = 64;
  localparam int REM_W        = 48;
  localparam int PROD_W       = 56;
  localparam int STEP_W       = 18;
  localparam int FPS_W        = 24;
  localparam int DEN_W        = 42;

  localparam logic [STEP_W-1:0] STEP_ONE   = 18'd65536;
  localparam logic [31:0]       STEP_MAX   = 32'd196608;
  localparam logic [31:0]       STEP_FLOOR = 32'd655;
  localparam logic [31:0]       STEP_MIN   = 32'd1;
  localparam logic [31:0]       FPS_MAX    = 32'd16777215;

  // status of the serial divider
  typedef struct packed {
    logic done;
    logic quo_big;
  } div_stat_t;

  // one result item
  typedef struct packed {
    logic [31:0]       game_time_ms;
    logic [31:0]       nonclipped_time_ms;
    logic [31:0]       pause_mode_time_ms;
    logic [31:0]       prev_time_1;
    logic [31:0]       prev_time_2;
    logic [31:0]       prev_time_3;
    logic [31:0]       prev_time_4;
    logic [31:0]       prev_nonclipped_ms;
    logic [STEP_W-1:0] time_step_q16;
    logic [STEP_W-1:0] old_time_step_q16;
    logic [FPS_W-1:0]  fps_q8;
    logic [31:0]       frame_count;
  } res_t;

endpackage

### sv/fta_in_if.sv
interface fta_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] elapsed_ticks;
  logic        user_pause;
  logic        code_pause;
  logic        snapshot_active;

  modport source (output valid, command, elapsed_ticks, user_pause, code_pause,
                  snapshot_active, input ready);
  modport sink (input valid, command, elapsed_ticks, user_pause, code_pause,
                snapshot_active, output ready);
endinterface

### sv/fta_out_if.sv
interface fta_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] game_time_ms;
  logic [31:0] nonclipped_time_ms;
  logic [31:0] pause_mode_time_ms;
  logic [31:0] prev_time_1;
  logic [31:0] prev_time_2;
  logic [31:0] prev_time_3;
  logic [31:0] prev_time_4;
  logic [31:0] prev_nonclipped_ms;
  logic [17:0] time_step_q16;
  logic [17:0] old_time_step_q16;
  logic [23:0] fps_q8;
  logic [31:0] frame_count;

  modport source (output valid, game_time_ms, nonclipped_time_ms, pause_mode_time_ms,
                  prev_time_1, prev_time_2, prev_time_3, prev_time_4, prev_nonclipped_ms,
                  time_step_q16, old_time_step_q16, fps_q8, frame_count, input ready);
  modport sink (input valid, game_time_ms, nonclipped_time_ms, pause_mode_time_ms,
                prev_time_1, prev_time_2, prev_time_3, prev_time_4, prev_nonclipped_ms,
                time_step_q16, old_time_step_q16, fps_q8, frame_count, output ready);
endinterface

### sv/fta_div.sv
module fta_div import fta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output div_stat_t        stat,
  output logic [31:0]      quo,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] num_r;
  logic [DIV_W-1:0] den_r;
  logic [DIV_W-1:0] rem_r;
  logic [31:0]      quo_r;
  logic             big_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, num_r[DIV_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      rem_r <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      big_r <= big_r | quo_r[31];
      quo_r <= {quo_r[30:0], fits};
    end
  end

  assign stat.done    = done_r;
  assign stat.quo_big = big_r;
  assign quo          = quo_r;
  assign rem          = rem_r;

endmodule

### sv/frame_time_accumulator_unit.sv
// Frame time accumulator. One request per rendered frame turns raw timer ticks into
// three millisecond clocks (pause-mode, unclipped game, clipped game) with exact
// sub-millisecond remainders, plus time step, four history times, fps and frame count.
// A frame request runs in order: shift-add multiply for the scaled ticks, shift-add
// multiply for the time-step divisor, six passes (start, quotient bits, hand-over)
// through one shared bit-serial divider, and a load of the result. A clip limit hit
// skips one pass and zero ticks skip the fps division. A stop request goes straight
// to result delivery. One request is worked at a time; a finished result sits in an
// output register, so the next request is taken while it waits.
module frame_time_accumulator_unit import fta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fta_in_if.sink                in_ch,
  fta_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DEN   = 4'd2;
  localparam logic [3:0] S_DIV_P = 4'd3;
  localparam logic [3:0] S_DIV_N = 4'd4;
  localparam logic [3:0] S_DIV_C = 4'd5;
  localparam logic [3:0] S_DIV_G = 4'd6;
  localparam logic [3:0] S_DIV_S = 4'd7;
  localparam logic [3:0] S_DIV_F = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [4:0] MUL_LAST = 5'd23;
  localparam logic [4:0] DEN_LAST = 5'd9;

  // configuration
  logic [31:0] ticks_per_ms_r;
  logic [23:0] time_scale_r;
  logic [15:0] clip_ms_r;
  logic [9:0]  step_len_r;

  // clocks and history
  logic [31:0]       game_ms_r, nc_ms_r, pause_ms_r, prev_nc_r, frames_r;
  logic [31:0]       hist_r [HIST_DEPTH];
  logic [REM_W-1:0]  game_rem_r, nc_rem_r, pause_rem_r;
  logic [STEP_W-1:0] step_now_r, step_before_r;
  logic [FPS_W-1:0]  fps_r;

  // sequencer and work registers
  logic [3:0]        state_r;
  logic              div_go_r;
  logic [31:0]       ticks_r;
  logic              paused_r, snap_r;
  logic [PROD_W-1:0] mc_r, acc_r, acc_nxt;
  logic [23:0]       mp_r;
  logic [4:0]        mcnt_r;
  logic [PROD_W-1:0] scaled_r;
  logic [DEN_W-1:0]  step_den_r;

  // result register
  res_t res_r;
  logic out_valid_r;

  // divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_num, div_den;
  div_stat_t        div_stat;
  logic [31:0]      div_quo;
  logic [DIV_W-1:0] div_rem;

  logic [31:0]       tpm_eff;
  logic [9:0]        sl_eff;
  logic [PROD_W-1:0] game_delta;
  logic [DIV_W-1:0]  one_ms, fps_num;
  logic [31:0]       step_q, fps_q;
  logic              in_acc;
  logic              out_free;

  fta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // effective dividers and derived operands
  always_comb begin
    tpm_eff    = (ticks_per_ms_r == '0) ? 32'd1 : ticks_per_ms_r;
    sl_eff     = (step_len_r == '0) ? 10'd1 : step_len_r;
    game_delta = paused_r ? '0 : scaled_r;
    one_ms     = {16'b0, tpm_eff, 16'b0};
    // 256000 * ticks_per_ms as shifts: 2^18 - 2^12 - 2^11
    fps_num    = ({14'b0, tpm_eff, 18'b0} - {20'b0, tpm_eff, 12'b0})
                 - {21'b0, tpm_eff, 11'b0};
    acc_nxt    = mp_r[0] ? acc_r + mc_r : acc_r;
  end

  // divider operand selection
  always_comb begin
    div_num = '0;
    div_den = one_ms;
    case (state_r)
      S_DIV_P: div_num = {8'b0, scaled_r} + {16'b0, pause_rem_r};
      S_DIV_N: div_num = {8'b0, game_delta} + {16'b0, nc_rem_r};
      S_DIV_C: div_num = {8'b0, game_delta};
      S_DIV_G: div_num = {8'b0, game_delta} + {16'b0, game_rem_r};
      S_DIV_S: begin
        div_num = {8'b0, game_delta};
        div_den = {22'b0, step_den_r};
      end
      S_DIV_F: begin
        div_num = fps_num;
        div_den = {32'b0, ticks_r};
      end
      default: begin
        div_num = '0;
        div_den = one_ms;
      end
    endcase
  end

  assign div_start = !div_go_r && (state_r inside {S_DIV_P, S_DIV_N, S_DIV_C, S_DIV_G,
                                                   S_DIV_S})
                     || (!div_go_r && state_r == S_DIV_F && ticks_r != '0);

  // time step clamp and fps saturation
  always_comb begin
    step_q = div_quo;
    if (!paused_r && !snap_r && step_q < STEP_FLOOR) step_q = STEP_FLOOR;
    if (step_q < STEP_MIN) step_q = STEP_MIN;
    if (div_stat.quo_big || step_q > STEP_MAX) step_q = STEP_MAX;
    fps_q = (div_stat.quo_big || div_quo > FPS_MAX) ? FPS_MAX : div_quo;
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_ms_r <= 32'd1;
      time_scale_r   <= 24'd65536;
      clip_ms_r      <= 16'd300;
      step_len_r     <= 10'd20;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TICKS_PER_MS: ticks_per_ms_r <= cfg_data;
        REG_TIME_SCALE:   time_scale_r   <= cfg_data[23:0];
        REG_CLIP_MS:      clip_ms_r      <= cfg_data[15:0];
        REG_STEP_LEN:     step_len_r     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      div_go_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      game_ms_r     <= '0;
      nc_ms_r       <= 32'd1;
      pause_ms_r    <= 32'd1;
      prev_nc_r     <= '0;
      frames_r      <= '0;
      game_rem_r    <= '0;
      nc_rem_r      <= '0;
      pause_rem_r   <= '0;
      step_now_r    <= STEP_ONE;
      step_before_r <= STEP_ONE;
      fps_r         <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      if (div_start) div_go_r <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            ticks_r  <= in_ch.elapsed_ticks;
            paused_r <= in_ch.user_pause | in_ch.code_pause;
            snap_r   <= in_ch.snapshot_active;
            prev_nc_r <= nc_ms_r;
            if (in_ch.command) begin
              // stop: sync history, drop remainders
              for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= game_ms_r;
              game_rem_r  <= '0;
              nc_rem_r    <= '0;
              pause_rem_r <= '0;
              state_r     <= S_DONE;
            end else begin
              for (int i = HIST_DEPTH - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
              hist_r[0] <= game_ms_r;
              frames_r  <= frames_r + 1'b1;
              mc_r      <= {24'b0, in_ch.elapsed_ticks};
              mp_r      <= time_scale_r;
              acc_r     <= '0;
              mcnt_r    <= '0;
              state_r   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // ticks times scale (unscaled ticks when paused), one multiplier bit a cycle
          acc_r  <= acc_nxt;
          mc_r   <= {mc_r[PROD_W-2:0], 1'b0};
          mp_r   <= {1'b0, mp_r[23:1]};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == MUL_LAST) begin
            scaled_r <= paused_r ? {8'b0, ticks_r, 16'b0} : acc_nxt;
            mc_r     <= {24'b0, tpm_eff};
            mp_r     <= {14'b0, sl_eff};
            acc_r    <= '0;
            mcnt_r   <= '0;
            state_r  <= S_DEN;
          end
        end
        S_DEN: begin
          // step divisor: ticks_per_ms times step length
          acc_r  <= acc_nxt;
          mc_r   <= {mc_r[PROD_W-2:0], 1'b0};
          mp_r   <= {1'b0, mp_r[23:1]};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == DEN_LAST) begin
            step_den_r <= acc_nxt[DEN_W-1:0];
            state_r    <= S_DIV_P;
          end
        end
        S_DIV_P: if (div_stat.done) begin
          div_go_r    <= 1'b0;
          pause_ms_r  <= pause_ms_r + div_quo;
          pause_rem_r <= div_rem[REM_W-1:0];
          state_r     <= S_DIV_N;
        end
        S_DIV_N: if (div_stat.done) begin
          div_go_r <= 1'b0;
          nc_ms_r  <= nc_ms_r + div_quo;
          nc_rem_r <= div_rem[REM_W-1:0];
          state_r  <= S_DIV_C;
        end
        S_DIV_C: if (div_stat.done) begin
          // clip limit reached: advance by exactly the limit, keep remainder
          div_go_r <= 1'b0;
          if (div_stat.quo_big || (div_quo >= {16'b0, clip_ms_r})) begin
            game_ms_r <= game_ms_r + {16'b0, clip_ms_r};
            state_r   <= S_DIV_S;
          end else begin
            state_r <= S_DIV_G;
          end
        end
        S_DIV_G: if (div_stat.done) begin
          div_go_r   <= 1'b0;
          game_ms_r  <= game_ms_r + div_quo;
          game_rem_r <= div_rem[REM_W-1:0];
          state_r    <= S_DIV_S;
        end
        S_DIV_S: if (div_stat.done) begin
          div_go_r      <= 1'b0;
          step_before_r <= step_now_r;
          step_now_r    <= step_q[STEP_W-1:0];
          state_r       <= S_DIV_F;
        end
        S_DIV_F: begin
          if (ticks_r == '0) begin
            fps_r   <= '0;
            state_r <= S_DONE;
          end else if (div_stat.done) begin
            div_go_r <= 1'b0;
            fps_r    <= fps_q[FPS_W-1:0];
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      res_r.game_time_ms       <= game_ms_r;
      res_r.nonclipped_time_ms <= nc_ms_r;
      res_r.pause_mode_time_ms <= pause_ms_r;
      res_r.prev_time_1        <= hist_r[0];
      res_r.prev_time_2        <= hist_r[1];
      res_r.prev_time_3        <= hist_r[2];
      res_r.prev_time_4        <= hist_r[3];
      res_r.prev_nonclipped_ms <= prev_nc_r;
      res_r.time_step_q16      <= step_now_r;
      res_r.old_time_step_q16  <= step_before_r;
      res_r.fps_q8             <= fps_r;
      res_r.frame_count        <= frames_r;
    end
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.game_time_ms       = res_r.game_time_ms;
  assign out_ch.nonclipped_time_ms = res_r.nonclipped_time_ms;
  assign out_ch.pause_mode_time_ms = res_r.pause_mode_time_ms;
  assign out_ch.prev_time_1        = res_r.prev_time_1;
  assign out_ch.prev_time_2        = res_r.prev_time_2;
  assign out_ch.prev_time_3        = res_r.prev_time_3;
  assign out_ch.prev_time_4        = res_r.prev_time_4;
  assign out_ch.prev_nonclipped_ms = res_r.prev_nonclipped_ms;
  assign out_ch.time_step_q16      = res_r.time_step_q16;
  assign out_ch.old_time_step_q16  = res_r.old_time_step_q16;
  assign out_ch.fps_q8             = res_r.fps_q8;
  assign out_ch.frame_count        = res_r.frame_count;

`ifndef SYNTHESIS
  // a stop request goes straight to result delivery
  a_stop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command |=> state_r == S_DONE)
    else $error("stop request did not go to result delivery");

  // the divider is never started in two consecutive cycles
  a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("divider started twice");

  // the stored time step stays inside its clamp
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> ({14'b0, step_now_r} >= STEP_MIN)
                          && ({14'b0, step_now_r} <= STEP_MAX))
    else $error("time step out of range");
`endif

endmodule

### tb/fta_tb_if.sv
`timescale 1ns / 100ps

// bundle of the channel interfaces is taken from the rtl; this file only holds
// the stimulus request type shared by the testbench
package fta_tb_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] elapsed_ticks;
    logic        user_pause;
    logic        code_pause;
    logic        snapshot_active;
  } frame_req_t;

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fta_pkg::*;
  import fta_tb_pkg::*;

  localparam int N_RANDOM   = 1700;
  localparam int TAIL_IDLE  = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_TICKS_PER_MS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fta_in_if  in_ch ();
  fta_out_if out_ch ();

  frame_time_accumulator_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the configuration and clocks
  logic [31:0] p_tpm;
  logic [23:0] p_scale;
  logic [15:0] p_clip;
  logic [9:0]  p_step_len;
  logic [31:0] p_game, p_nonclip, p_pause, p_prev_nc, p_frames;
  logic [31:0] p_hist [4];
  logic [63:0] p_rem_game, p_rem_nc, p_rem_pause;
  logic [17:0] p_step, p_step_old;
  logic [23:0] p_fps;

  res_t expected_frames [$];
  int   n_fail = 0;
  int   n_checked = 0;
  int   n_stops = 0;
  bit   no_idle = 1'b0;
  bit   stim_done = 1'b0;

  function automatic logic [63:0] one_ms_ticks();
    return {32'd0, (p_tpm == 0) ? 32'd1 : p_tpm} << FRAC_BITS;
  endfunction

  task automatic add_ticks(input logic [63:0] delta, ref logic [31:0] clk_ms,
                           ref logic [63:0] rem);
    logic [63:0] total;
    total  = delta + rem;
    clk_ms = clk_ms + 32'(total / one_ms_ticks());
    rem    = total % one_ms_ticks();
  endtask

  task automatic predict_reset();
    p_tpm = 1; p_scale = 65536; p_clip = 300; p_step_len = 20;
    p_game = 0; p_nonclip = 1; p_pause = 1; p_prev_nc = 0; p_frames = 0;
    foreach (p_hist[i]) p_hist[i] = 0;
    p_rem_game = 0; p_rem_nc = 0; p_rem_pause = 0;
    p_step = STEP_ONE; p_step_old = STEP_ONE; p_fps = 0;
  endtask

  task automatic predict_frame(input frame_req_t r, output res_t res);
    logic [63:0] ticks, scaled, game_delta, den, q, fps;
    logic paused;
    ticks  = {32'd0, r.elapsed_ticks};
    paused = r.user_pause | r.code_pause;
    if (r.command) begin
      foreach (p_hist[i]) p_hist[i] = p_game;
      p_prev_nc = p_nonclip;
      p_rem_game = 0; p_rem_nc = 0; p_rem_pause = 0;
    end else begin
      for (int i = 3; i > 0; i--) p_hist[i] = p_hist[i-1];
      p_hist[0] = p_game;
      p_prev_nc = p_nonclip;
      if (ticks == 0) p_fps = 0;
      else begin
        fps   = (64'd256000 * (one_ms_ticks() >> FRAC_BITS)) / ticks;
        p_fps = (fps > FPS_MAX) ? FPS_MAX[23:0] : fps[23:0];
      end
      scaled = paused ? (ticks << FRAC_BITS) : ticks * {40'd0, p_scale};
      add_ticks(scaled, p_pause, p_rem_pause);
      game_delta = paused ? 64'd0 : scaled;
      add_ticks(game_delta, p_nonclip, p_rem_nc);
      // clip limit hit: advance by exactly clip_ms, remainder untouched
      if (game_delta / one_ms_ticks() >= {48'd0, p_clip}) p_game = p_game + p_clip;
      else add_ticks(game_delta, p_game, p_rem_game);
      den = (one_ms_ticks() >> FRAC_BITS) * ((p_step_len == 0) ? 64'd1 : p_step_len);
      q = game_delta / den;
      if (!paused && !r.snapshot_active && q < STEP_FLOOR) q = STEP_FLOOR;
      if (q < STEP_MIN) q = STEP_MIN;
      if (q > STEP_MAX) q = STEP_MAX;
      p_step_old = p_step;
      p_step = q[17:0];
      p_frames++;
    end
    res = '{p_game, p_nonclip, p_pause, p_hist[0], p_hist[1], p_hist[2], p_hist[3],
            p_prev_nc, p_step, p_step_old, p_fps, p_frames};
  endtask

  // configuration write, only with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TICKS_PER_MS: p_tpm = val;
      REG_TIME_SCALE:   p_scale = val[23:0];
      REG_CLIP_MS:      p_clip = val[15:0];
      REG_STEP_LEN:     p_step_len = val[9:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (TAIL_IDLE) @(posedge clk);
  endtask

  task automatic idle_burst();
    if (!no_idle && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  // sends one request; predicts when it is accepted
  task automatic send_frame(input frame_req_t r, input bit has_fixed, input res_t fixed);
    res_t res;
    idle_burst();
    in_ch.valid = 1'b1;
    {in_ch.command, in_ch.elapsed_ticks, in_ch.user_pause, in_ch.code_pause,
     in_ch.snapshot_active} = r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_frame(r, res);
    if (has_fixed && res != fixed) begin
      n_fail++;
      $display("table row disagrees with predictor: %p vs %p", fixed, res);
    end
    expected_frames.push_back(res);
    if (r.command) n_stops++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_t got, want;
      got = '{out_ch.game_time_ms, out_ch.nonclipped_time_ms, out_ch.pause_mode_time_ms,
              out_ch.prev_time_1, out_ch.prev_time_2, out_ch.prev_time_3,
              out_ch.prev_time_4, out_ch.prev_nonclipped_ms, out_ch.time_step_q16,
              out_ch.old_time_step_q16, out_ch.fps_q8, out_ch.frame_count};
      if (expected_frames.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_frames.pop_front();
        n_checked++;
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle || $urandom_range(0, 3) != 0) out_ch.ready = 1'b1;
      else begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // directed table; fixed expectation only for the first frame after reset
  frame_req_t dir_req [] = '{
    '{1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'd1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'd250, 1'b1, 1'b0, 1'b0},
    '{1'b0, 32'd7, 1'b0, 1'b1, 1'b1},
    '{1'b0, 32'd3, 1'b0, 1'b0, 1'b1},
    '{1'b1, 32'd0, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'd60, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'd20, 1'b1, 1'b1, 1'b1},
    '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1},
    '{1'b0, 32'd299, 1'b0, 1'b0, 1'b0},
    '{1'b0, 32'd300, 1'b0, 1'b0, 1'b0}
  };

  function automatic frame_req_t rand_req();
    frame_req_t r;
    r.command = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 4))
      0: r.elapsed_ticks = $urandom;
      1: r.elapsed_ticks = $urandom_range(0, 3);
      default: r.elapsed_ticks = $urandom_range(0, 200000);
    endcase
    r.user_pause = ($urandom_range(0, 7) == 0);
    r.code_pause = ($urandom_range(0, 7) == 0);
    r.snapshot_active = ($urandom_range(0, 5) == 0);
    return r;
  endfunction

  initial begin
    res_t fixed;
    int   phase_len;
    in_ch.valid = 1'b0; in_ch.command = 1'b0; in_ch.elapsed_ticks = '0;
    in_ch.user_pause = 1'b0; in_ch.code_pause = 1'b0; in_ch.snapshot_active = 1'b0;
    predict_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // default settings: first row with zero ticks reads straight off the reset state
    fixed = '{32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1,
              18'd655, STEP_ONE, 24'd0, 32'd1};
    foreach (dir_req[i]) send_frame(dir_req[i], i == 0, fixed);
    wait_drain();

    // extremes of every register
    write_reg(REG_TICKS_PER_MS, 32'hFFFF_FFFF);
    write_reg(REG_TIME_SCALE, 32'h00FF_FFFF);
    write_reg(REG_CLIP_MS, 32'd65535);
    write_reg(REG_STEP_LEN, 32'd1000);
    foreach (dir_req[i]) send_frame(dir_req[i], 1'b0, fixed);
    wait_drain();
    write_reg(REG_TICKS_PER_MS, 32'd0);
    write_reg(REG_TIME_SCALE, 32'd0);
    write_reg(REG_CLIP_MS, 32'd1);
    write_reg(REG_STEP_LEN, 32'd0);
    foreach (dir_req[i]) send_frame(dir_req[i], 1'b0, fixed);
    wait_drain();

    // random phases with random settings; last phase runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_TICKS_PER_MS, ($urandom_range(0, 2) == 0) ? $urandom
                                                              : $urandom_range(1, 3000));
      write_reg(REG_TIME_SCALE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                                            : $urandom_range(0, 200000));
      write_reg(REG_CLIP_MS, $urandom_range(1, 65535) >> $urandom_range(0, 15));
      write_reg(REG_STEP_LEN, $urandom_range(0, 1023));
      if (ph == 7) no_idle = 1'b1;
      phase_len = N_RANDOM / 8;
      repeat (phase_len) send_frame(rand_req(), 1'b0, fixed);
      wait_drain();
    end
    stim_done = 1'b1;

    $display("checked %0d results, %0d of them stop requests, over 11 register settings",
             n_checked, n_stops);
    if (n_fail == 0 && expected_frames.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog: ~1800 requests with stalls fit easily
  initial begin
    #(8ns * 3_000_000);
    $display("timeout with %0d results outstanding", expected_frames.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
